### hdl/greedy_colour_class_ordering_defines.svh
// Assertion macros shared by the greedy colouring block.
// All of them sample on clk_i and are disabled while rst_ni is low.
`ifndef GREEDY_COLOUR_CLASS_ORDERING_DEFINES_SVH
`define GREEDY_COLOUR_CLASS_ORDERING_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define GCCO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gcco: same-cycle check failed");

// Check that an antecedent implies a consequent in the next cycle.
`define GCCO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gcco: next-cycle check failed");

`endif

### hdl/gcco_pkg.sv
`default_nettype none

package gcco_pkg;

  // Row and set width, fixed by the request format
  localparam int unsigned RowW = 64;
  localparam int unsigned VtxW = 6;
  localparam int unsigned ColW = 7;

  // Opcode values
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_COLOUR = 1'b1;

  typedef struct packed {
    logic            opcode;
    logic [VtxW-1:0] row_index;
    logic [RowW-1:0] vertex_bits;
  } gcco_req_t;

  typedef struct packed {
    logic [VtxW-1:0] vertex;
    logic [ColW-1:0] colour;
    logic [VtxW-1:0] position;
    logic            last;
  } gcco_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PICK,
    ST_APPLY
  } gcco_state_e;

  // Index of the lowest set bit: isolate it with one add, then encode
  function automatic logic [VtxW-1:0] gcco_lowest(input logic [RowW-1:0] x);
    logic [RowW-1:0] one_hot;
    logic [VtxW-1:0] idx;
    one_hot = x & (~x + RowW'(1));
    idx = '0;
    for (int j = 0; j < RowW; j++) begin
      idx = idx | (one_hot[j] ? VtxW'(j) : '0);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

### hdl/gcco_adj_mem.sv
`default_nettype none

module gcco_adj_mem
  import gcco_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire logic [RowW-1:0] wdata_i,
  input  wire logic            re_i,
  input  wire logic [AW-1:0]   raddr_i,
  output logic      [RowW-1:0] rdata_o
);

  logic [RowW-1:0] mem_q [DEPTH];
  logic [RowW-1:0] rdata_q;

  // Write one adjacency row
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/gcco_engine.sv
`default_nettype none
`include "greedy_colour_class_ordering_defines.svh"

module gcco_engine
  import gcco_pkg::*;
#(
  parameter int unsigned VERTICES = 64,
  parameter int unsigned AW       = 6
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire gcco_req_t       req_i,
  output logic                 busy,
  output logic                 rd_en_o,
  output logic      [AW-1:0]   rd_addr_o,
  input  wire logic [RowW-1:0] rd_data_i,
  output logic                 res_valid_o,
  output gcco_res_t            res_o
);

  localparam logic [RowW-1:0] VMask = {RowW{1'b1}} >> (RowW - VERTICES);

  gcco_state_e     state_q, state_d;
  logic [RowW-1:0] left_q, left_d;
  logic [RowW-1:0] cls_q, cls_d;
  logic [ColW-1:0] colour_q, colour_d;
  logic [VtxW-1:0] pos_q, pos_d;
  logic            res_valid_q, res_valid_d;
  gcco_res_t       res_q, res_d;

  logic [RowW-1:0] req_set;
  logic            req_colour;
  logic [VtxW-1:0] pick_idx;
  logic [RowW-1:0] pick_bit;
  logic [RowW-1:0] left_after;
  logic [RowW-1:0] cls_pruned;

  assign req_set    = req_i.vertex_bits & VMask;
  assign req_colour = start && !busy && (req_i.opcode == OP_COLOUR);
  assign pick_idx   = gcco_lowest(cls_q);
  assign pick_bit   = RowW'(1) << pick_idx;
  assign left_after = left_q & ~pick_bit;
  assign cls_pruned = cls_q & ~rd_data_i;

  // Hold state and class masks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q   <= left_d;
    cls_q    <= cls_d;
    colour_q <= colour_d;
    pos_q    <= pos_d;
    res_q    <= res_d;
  end

  // Pick the lowest vertex of the class, then prune its neighbors; open a new class when it empties
  always_comb begin
    state_d     = state_q;
    left_d      = left_q;
    cls_d       = cls_q;
    colour_d    = colour_q;
    pos_d       = pos_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = pick_idx[AW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (req_colour && (req_set != '0)) begin
          left_d   = req_set;
          cls_d    = req_set;
          colour_d = ColW'(1);
          pos_d    = '0;
          state_d  = ST_PICK;
        end
      end
      ST_PICK: begin
        rd_en_o         = 1'b1;
        left_d          = left_after;
        cls_d           = cls_q & ~pick_bit;
        res_valid_d     = 1'b1;
        res_d.vertex    = pick_idx;
        res_d.colour    = colour_q;
        res_d.position  = pos_q;
        res_d.last      = (left_after == '0);
        pos_d           = pos_q + VtxW'(1);
        state_d         = ST_APPLY;
      end
      ST_APPLY: begin
        priority if (cls_pruned != '0) begin
          cls_d   = cls_pruned;
          state_d = ST_PICK;
        end else if (left_q != '0) begin
          // open the next colour class from what is left
          cls_d    = left_q;
          colour_d = colour_q + ColW'(1);
          state_d  = ST_PICK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `GCCO_ASSERT_IMP(a_res_while_busy, res_valid_q, busy)
  `GCCO_ASSERT_NXT(a_last_ends, res_valid_q && res_q.last, !busy)
  `GCCO_ASSERT_NXT(a_res_spacing, res_valid_q && !res_q.last, !res_valid_q)
  `GCCO_ASSERT_NXT(a_colour_starts, req_colour && (req_set != '0), busy)
  `GCCO_ASSERT_IMP(a_pick_nonempty, state_q == ST_PICK, cls_q != '0)

endmodule

`default_nettype wire

### hdl/greedy_colour_class_ordering.sv
// Load request: busy stays low and no result is given.
// Colour request of N vertices: busy until the last result; per vertex, the pick
// state registers and strobes its result, then the apply state prunes the class with
// the row read from the registered adjacency memory; results never come back to back.
// Results cannot be stalled. Reset clears control only; adjacency rows are
// undefined until loaded, with no clearing pass.
`default_nettype none

module greedy_colour_class_ordering
  import gcco_pkg::*;
#(
  parameter int unsigned VERTICES = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire gcco_req_t req_i,
  output logic           res_valid_o,
  output gcco_res_t      res_o
);

  localparam int unsigned AW = $clog2(VERTICES);
  localparam logic [RowW-1:0] VMask = {RowW{1'b1}} >> (RowW - VERTICES);

  logic            wr_en;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [RowW-1:0] rd_data;

  // Write a row only for an in-range load
  assign wr_en = start && !busy && (req_i.opcode == OP_LOAD) &&
                 ({1'b0, req_i.row_index} < (VtxW + 1)'(VERTICES));

  gcco_adj_mem #(
    .DEPTH (VERTICES),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (req_i.row_index[AW-1:0]),
    .wdata_i (req_i.vertex_bits & VMask),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  gcco_engine #(
    .VERTICES (VERTICES),
    .AW       (AW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_i       (req_i),
    .busy        (busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
